// ===== hdl/mtrk_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mtrk_pkg
// Shared constants, register codes and pipeline structs for the multi-turn
// encoder tracker.
// ----------------------------------------------------------------------------
package mtrk_pkg;

  localparam int NUM_MOTORS = 8;
  localparam int WINDOW_LEN = 5;

  localparam int ST_AW     = (NUM_MOTORS > 1) ? $clog2(NUM_MOTORS) : 1;
  localparam int WIN_DEPTH = NUM_MOTORS * WINDOW_LEN;
  localparam int WIN_AW    = (WIN_DEPTH > 1) ? $clog2(WIN_DEPTH) : 1;
  localparam int PTR_W     = 4;
  localparam int ANGLE_W   = 13;

  localparam logic signed [13:0] HALF_TURN = 14'sd4096;
  localparam logic signed [14:0] FULL_TURN = 15'sd8192;
  localparam logic [8:0]         DEG_TURN  = 9'd360;

  localparam logic [5:0] COUNT_MAX   = 6'd63;
  localparam logic [5:0] LIMIT_RESET = 6'd50;
  localparam logic [7:0] MASK_RESET  = 8'd15;

  localparam logic signed [15:0] TURN_MAX = 16'sh7fff;
  localparam logic signed [15:0] TURN_MIN = 16'sh8000;

  // Window mean: multiply by a rounded-up reciprocal, exact for |sum| < 2^17
  localparam int RECIP_SH = 22;
  localparam int RECIP_W  = RECIP_SH + 1;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'((2**RECIP_SH + WINDOW_LEN - 1) / WINDOW_LEN);

  localparam int OFIFO_DEPTH = 8;
  localparam int OFIFO_AW    = $clog2(OFIFO_DEPTH);
  localparam int OFIFO_CW    = $clog2(OFIFO_DEPTH + 1);

  typedef enum logic [0:0] {
    REG_CALIB_LIMIT = 1'b0,
    REG_CALIB_MASK  = 1'b1
  } cfg_reg_t;

  // Per-motor state word
  typedef struct packed {
    logic [5:0]         frame_count;
    logic [12:0]        last_angle;
    logic [12:0]        zero_offset;
    logic signed [15:0] turn_count;
    logic [PTR_W-1:0]   window_pointer;
    logic signed [17:0] window_sum;
  } mstate_t;

  // Update stage to scaling stage
  typedef struct packed {
    logic [2:0]         motor;
    logic               calib;
    logic signed [15:0] speed;
    logic signed [13:0] step;
    logic signed [15:0] turns;
    logic signed [29:0] total;
    logic signed [17:0] sum;
  } upd_t;

  // Finished result item
  typedef struct packed {
    logic [2:0]         motor;
    logic               calib;
    logic signed [15:0] speed;
    logic signed [13:0] step;
    logic signed [15:0] turns;
    logic signed [29:0] total;
    logic signed [24:0] degrees;
    logic signed [13:0] filt;
  } res_t;

endpackage
`default_nettype wire

// ===== hdl/motor_encoder_multiturn_tracker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// motor_encoder_multiturn_tracker
// Multi-turn rotor angle tracker with offset calibration and a moving
// average of angle steps, per motor slot.
// ----------------------------------------------------------------------------
// Path from input accept to m_axis_tvalid: state read, window read and write
//   back, scale multiply, scale finish, output queue. Throughput: one item per
//   cycle while s_axis_tready is high; the state and window memories each
//   do one read and one write a cycle, with forwarding between back-to-back items.
// Reset: synchronous; per-entry valid bits make all state read as zero at
//   once, no clearing pass. Registers return to limit 50, mask 0x0f.
// ----------------------------------------------------------------------------
module motor_encoder_multiturn_tracker import mtrk_pkg::*; (
  input  wire          clk,
  input  wire          rst,
  input  wire          s_axis_tvalid,
  output logic         s_axis_tready,
  input  wire [31:0]   s_axis_tdata,   // angle_raw[12:0], speed_raw[28:13], zero pad
  input  wire [2:0]    s_axis_tuser,   // motor[2:0]
  output logic         m_axis_tvalid,
  input  wire          m_axis_tready,
  output logic [119:0] m_axis_tdata,   // speed_out[15:0], angle_step[29:16],
                                       // turns[45:30], total_counts[75:46],
                                       // total_degrees[100:76],
                                       // filtered_step[114:101], zero pad
  output logic [3:0]   m_axis_tuser,   // motor_out[2:0], calibrating[3]
  input  wire          cfg_valid,
  output logic         cfg_ready,
  input  wire [0:0]    cfg_index,
  input  wire [7:0]    cfg_data
);

  logic [5:0]          calib_limit;
  logic [7:0]          calib_mask;
  logic                in_take;
  logic                in_valid;
  logic                out_pop;
  logic [OFIFO_CW-1:0] credit;
  logic                upd_valid;
  upd_t                upd;
  logic                res_valid;
  res_t                res;
  res_t                out_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      calib_limit <= LIMIT_RESET;
      calib_mask  <= MASK_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_CALIB_LIMIT: calib_limit <= cfg_data[5:0];
        REG_CALIB_MASK:  calib_mask  <= cfg_data;
        default:         calib_limit <= calib_limit;
      endcase
    end
  end

  // Reserve a queue slot for every item that will give a result
  assign in_take       = s_axis_tvalid && s_axis_tready;
  assign in_valid      = in_take && (int'(s_axis_tuser) < NUM_MOTORS);
  assign out_pop       = m_axis_tvalid && m_axis_tready;
  assign s_axis_tready = (credit != OFIFO_CW'(OFIFO_DEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      credit <= '0;
    end else begin
      case ({in_valid, out_pop})
        2'b10:   credit <= credit + OFIFO_CW'(1);
        2'b01:   credit <= credit - OFIFO_CW'(1);
        default: credit <= credit;
      endcase
    end
  end

  mtrk_update u_update (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_motor    (s_axis_tuser),
    .in_angle    (s_axis_tdata[12:0]),
    .in_speed    (s_axis_tdata[28:13]),
    .calib_limit (calib_limit),
    .calib_mask  (calib_mask),
    .upd_valid   (upd_valid),
    .upd         (upd)
  );

  mtrk_scale u_scale (
    .clk       (clk),
    .rst       (rst),
    .upd_valid (upd_valid),
    .upd       (upd),
    .res_valid (res_valid),
    .res       (res)
  );

  mtrk_ofifo u_ofifo (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .push_data (res),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (out_data)
  );

  assign m_axis_tdata = {5'd0, out_data.filt, out_data.degrees, out_data.total,
                         out_data.turns, out_data.step, out_data.speed};
  assign m_axis_tuser = {out_data.calib, out_data.motor};

  a_result_reserved : assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (credit != '0))
    else $error("result item without a reserved slot");

  a_credit_bound : assert property (@(posedge clk) disable iff (rst)
    int'(credit) <= OFIFO_DEPTH)
    else $error("credit count past queue depth");

endmodule
`default_nettype wire

// ===== hdl/mtrk_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mtrk_ram
// Simple dual-port RAM, one write port, one read port with registered data.
// A read of the address written in the same cycle returns the old data.
// ----------------------------------------------------------------------------
module mtrk_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire                                   clk,
  input  wire                                   we,
  input  wire [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire [WIDTH-1:0]                       wdata,
  input  wire [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== hdl/mtrk_update.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mtrk_update
// Read-modify-write of the per-motor state and step window memories:
// unwrap, turn count, offset capture and running window sum.
// ----------------------------------------------------------------------------
module mtrk_update import mtrk_pkg::*; (
  input  wire                clk,
  input  wire                rst,
  input  wire                in_valid,
  input  wire [2:0]          in_motor,
  input  wire [12:0]         in_angle,
  input  wire signed [15:0]  in_speed,
  input  wire [5:0]          calib_limit,
  input  wire [7:0]          calib_mask,
  output logic               upd_valid,
  output upd_t               upd
);

  // stage 1: state read data
  logic               p1_valid;
  logic [2:0]         p1_motor;
  logic [ST_AW-1:0]   p1_addr;
  logic [12:0]        p1_angle;
  logic signed [15:0] p1_speed;
  logic               p1_st_vld;
  mstate_t            st_rdata;
  mstate_t            st_p1;
  logic [PTR_W-1:0]   p1_ptr;
  logic [WIN_AW-1:0]  win_raddr;
  logic               win_hit;

  // stage 2: window read data, compute and write back
  logic               p2_valid;
  logic [2:0]         p2_motor;
  logic [ST_AW-1:0]   p2_addr;
  logic [12:0]        p2_angle;
  logic signed [15:0] p2_speed;
  mstate_t            p2_st;
  logic [PTR_W-1:0]   p2_ptr;
  logic [WIN_AW-1:0]  p2_waddr;
  logic               p2_win_hit;
  logic signed [13:0] p2_win_fwd;
  logic               p2_win_vld;
  logic [13:0]        win_rdata;

  logic               calib;
  logic signed [13:0] diff;
  logic signed [14:0] diff_x;
  logic signed [14:0] step_x;
  logic signed [13:0] step;
  logic signed [15:0] turn_new;
  logic signed [29:0] total;
  logic signed [13:0] win_old;
  logic signed [17:0] sum_new;
  logic [PTR_W:0]     ptr_inc;
  logic [PTR_W-1:0]   ptr_next;
  mstate_t            st_new;
  logic               st_we;
  logic               win_we;

  // last write, for a read issued on the same edge
  logic               wb_vld;
  logic [ST_AW-1:0]   wb_addr;
  mstate_t            wb_data;

  logic [NUM_MOTORS-1:0] st_vld;
  logic [WIN_DEPTH-1:0]  win_vld;

  mtrk_ram #(
    .WIDTH ($bits(mstate_t)),
    .DEPTH (NUM_MOTORS)
  ) u_state_ram (
    .clk   (clk),
    .we    (st_we),
    .waddr (p2_addr),
    .wdata (st_new),
    .raddr (ST_AW'(in_motor)),
    .rdata (st_rdata)
  );

  mtrk_ram #(
    .WIDTH (14),
    .DEPTH (WIN_DEPTH)
  ) u_window_ram (
    .clk   (clk),
    .we    (win_we),
    .waddr (p2_waddr),
    .wdata (step),
    .raddr (win_raddr),
    .rdata (win_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
    end else begin
      p1_valid <= in_valid;
    end
    p1_motor  <= in_motor;
    p1_addr   <= ST_AW'(in_motor);
    p1_angle  <= in_angle;
    p1_speed  <= in_speed;
    p1_st_vld <= st_vld[ST_AW'(in_motor)];
  end

  // Forward the newest state: the write in flight, then the one just done
  always_comb begin
    if (p2_valid && (p2_addr == p1_addr)) begin
      st_p1 = st_new;
    end else if (wb_vld && (wb_addr == p1_addr)) begin
      st_p1 = wb_data;
    end else if (p1_st_vld) begin
      st_p1 = st_rdata;
    end else begin
      st_p1 = '0;
    end
  end

  assign p1_ptr    = ({1'b0, st_p1.window_pointer} >= (PTR_W+1)'(WINDOW_LEN)) ?
                     '0 : st_p1.window_pointer;
  assign win_raddr = WIN_AW'(int'(p1_motor) * WINDOW_LEN + int'(p1_ptr));
  assign win_hit   = win_we && (p2_waddr == win_raddr);

  always_ff @(posedge clk) begin
    if (rst) begin
      p2_valid <= 1'b0;
    end else begin
      p2_valid <= p1_valid;
    end
    p2_motor   <= p1_motor;
    p2_addr    <= p1_addr;
    p2_angle   <= p1_angle;
    p2_speed   <= p1_speed;
    p2_st      <= st_p1;
    p2_ptr     <= p1_ptr;
    p2_waddr   <= win_raddr;
    p2_win_hit <= win_hit;
    p2_win_fwd <= step;
    p2_win_vld <= win_vld[win_raddr];
  end

  assign calib = calib_mask[p2_motor] && (p2_st.frame_count <= calib_limit);

  always_comb begin
    diff   = $signed({1'b0, p2_angle}) - $signed({1'b0, p2_st.last_angle});
    diff_x = {diff[13], diff};
    if (diff > HALF_TURN) begin
      step_x   = diff_x - FULL_TURN;
      turn_new = (p2_st.turn_count == TURN_MIN) ? p2_st.turn_count :
                 p2_st.turn_count - 16'sd1;
    end else if (diff < -HALF_TURN) begin
      step_x   = diff_x + FULL_TURN;
      turn_new = (p2_st.turn_count == TURN_MAX) ? p2_st.turn_count :
                 p2_st.turn_count + 16'sd1;
    end else begin
      step_x   = diff_x;
      turn_new = p2_st.turn_count;
    end
    step  = step_x[13:0];
    total = {turn_new[15], turn_new, {ANGLE_W{1'b0}}} + 30'(p2_angle) -
            30'(p2_st.zero_offset);

    // drop the oldest step, add the new one
    if (p2_win_hit) begin
      win_old = p2_win_fwd;
    end else if (p2_win_vld) begin
      win_old = win_rdata;
    end else begin
      win_old = '0;
    end
    sum_new  = p2_st.window_sum - {{4{win_old[13]}}, win_old} + {{4{step[13]}}, step};
    ptr_inc  = {1'b0, p2_ptr} + (PTR_W+1)'(1);
    ptr_next = (ptr_inc >= (PTR_W+1)'(WINDOW_LEN)) ? '0 : ptr_inc[PTR_W-1:0];

    st_new = p2_st;
    st_new.frame_count = (p2_st.frame_count == COUNT_MAX) ? p2_st.frame_count :
                         p2_st.frame_count + 6'd1;
    st_new.last_angle  = p2_angle;
    if (calib) begin
      st_new.zero_offset = p2_angle;
    end else begin
      st_new.turn_count     = turn_new;
      st_new.window_pointer = ptr_next;
      st_new.window_sum     = sum_new;
    end
  end

  assign st_we  = p2_valid;
  assign win_we = p2_valid && !calib;

  always_ff @(posedge clk) begin
    if (rst) begin
      wb_vld  <= 1'b0;
      st_vld  <= '0;
      win_vld <= '0;
    end else begin
      wb_vld <= st_we;
      if (st_we) begin
        st_vld[p2_addr] <= 1'b1;
      end
      if (win_we) begin
        win_vld[p2_waddr] <= 1'b1;
      end
    end
    wb_addr <= p2_addr;
    wb_data <= st_new;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      upd_valid <= 1'b0;
    end else begin
      upd_valid <= p2_valid;
    end
    upd.motor <= p2_motor;
    upd.calib <= calib;
    upd.speed <= p2_speed;
    upd.step  <= calib ? 14'sd0 : step;
    upd.turns <= calib ? p2_st.turn_count : turn_new;
    upd.total <= calib ? 30'sd0 : total;
    upd.sum   <= calib ? 18'sd0 : sum_new;
  end

  a_p1_advances : assert property (@(posedge clk) disable iff (rst)
    p1_valid |=> p2_valid)
    else $error("stage 1 item lost");

  a_window_in_slot : assert property (@(posedge clk) disable iff (rst)
    win_we |-> (int'(p2_waddr) >= int'(p2_motor) * WINDOW_LEN) &&
               (int'(p2_waddr) < (int'(p2_motor) + 1) * WINDOW_LEN))
    else $error("window write outside motor slot");

endmodule
`default_nettype wire

// ===== hdl/mtrk_scale.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mtrk_scale
// Two-stage scaling: total counts to degrees and window sum to mean,
// both truncated toward zero through sign and magnitude.
// ----------------------------------------------------------------------------
module mtrk_scale import mtrk_pkg::*; (
  input  wire         clk,
  input  wire         rst,
  input  wire         upd_valid,
  input  upd_t        upd,
  output logic        res_valid,
  output res_t        res
);

  localparam int FP_W = 17 + RECIP_W;

  logic [29:0]        abs_total;
  logic [16:0]        abs_sum;
  logic [17:0]        neg_sum;

  logic               a_valid;
  logic [2:0]         a_motor;
  logic               a_calib;
  logic signed [15:0] a_speed;
  logic signed [13:0] a_step;
  logic signed [15:0] a_turns;
  logic signed [29:0] a_total;
  logic               a_deg_neg;
  logic [38:0]        a_deg_prod;
  logic               a_filt_neg;
  logic [FP_W-1:0]    a_filt_prod;

  logic [24:0]        deg_mag;
  logic [16:0]        filt_mag;

  always_comb begin
    abs_total = upd.total[29] ? 30'(-upd.total) : 30'(upd.total);
    neg_sum   = 18'(-upd.sum);
    abs_sum   = upd.sum[17] ? neg_sum[16:0] : upd.sum[16:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else begin
      a_valid <= upd_valid;
    end
    a_motor     <= upd.motor;
    a_calib     <= upd.calib;
    a_speed     <= upd.speed;
    a_step      <= upd.step;
    a_turns     <= upd.turns;
    a_total     <= upd.total;
    a_deg_neg   <= upd.total[29];
    a_deg_prod  <= 39'(abs_total) * 39'(DEG_TURN);
    a_filt_neg  <= upd.sum[17];
    a_filt_prod <= FP_W'(abs_sum) * FP_W'(RECIP);
  end

  assign deg_mag  = a_deg_prod[ANGLE_W +: 25];
  assign filt_mag = a_filt_prod[RECIP_SH +: 17];

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else begin
      res_valid <= a_valid;
    end
    res.motor   <= a_motor;
    res.calib   <= a_calib;
    res.speed   <= a_speed;
    res.step    <= a_step;
    res.turns   <= a_turns;
    res.total   <= a_total;
    res.degrees <= a_deg_neg ? -deg_mag : deg_mag;
    res.filt    <= a_filt_neg ? -filt_mag[13:0] : filt_mag[13:0];
  end

endmodule
`default_nettype wire

// ===== hdl/mtrk_ofifo.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mtrk_ofifo
// Output queue for finished result items; decouples the pipeline from
// downstream stalls.
// ----------------------------------------------------------------------------
module mtrk_ofifo import mtrk_pkg::*; (
  input  wire         clk,
  input  wire         rst,
  input  wire         push,
  input  res_t        push_data,
  output logic        out_valid,
  input  wire         out_ready,
  output res_t        out_data
);

  res_t                entries [OFIFO_DEPTH];
  logic [OFIFO_AW-1:0] wr_ptr;
  logic [OFIFO_AW-1:0] rd_ptr;
  logic [OFIFO_CW-1:0] count;
  logic                pop;

  assign out_valid = (count != '0);
  assign pop       = out_valid && out_ready;
  assign out_data  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + OFIFO_AW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + OFIFO_AW'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + OFIFO_CW'(1);
        2'b01:   count <= count - OFIFO_CW'(1);
        default: count <= count;
      endcase
    end
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  a_no_overflow : assert property (@(posedge clk) disable iff (rst)
    push |-> (count != OFIFO_CW'(OFIFO_DEPTH)) || pop)
    else $error("output queue overflow");

endmodule
`default_nettype wire

// ===== dv/motor_encoder_multiturn_tracker_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// motor_encoder_multiturn_tracker_test
// Self-checking bench for the multi-turn encoder tracker. Feedback frames go
// in on the slave stream; a per-motor tracker built into the bench works out
// each result item, and every item on the master stream is checked field by
// field against the oldest pending one. Covers wrap edges, offset capture
// under several calibration settings, output back-pressure, fast spins in
// both directions and a long random stream.
// ----------------------------------------------------------------------------
module motor_encoder_multiturn_tracker_test;
  import mtrk_pkg::cfg_reg_t;
  import mtrk_pkg::REG_CALIB_LIMIT;
  import mtrk_pkg::REG_CALIB_MASK;

  localparam int MOTORS      = 8;
  localparam int WIN_LEN     = 5;
  localparam int TURN_COUNTS = 8192;
  localparam int HALF_COUNTS = 4096;
  localparam int TURN_TOP    = 32767;
  localparam int TURN_BOTTOM = -32768;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASE_ITEMS = 200;
  localparam int SPIN_ITEMS  = 30;

  typedef struct packed {
    logic [2:0]         motor;
    logic               calib;
    logic signed [15:0] speed;
    logic signed [13:0] step;
    logic signed [15:0] turns;
    logic signed [29:0] total;
    logic signed [24:0] degrees;
    logic signed [13:0] filt;
  } frame_result_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [31:0]  s_axis_tdata = '0;   // angle_raw[12:0], speed_raw[28:13], zero pad
  logic [2:0]   s_axis_tuser = '0;   // motor[2:0]
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [119:0] m_axis_tdata;        // speed_out, angle_step, turns, total_counts,
                                     // total_degrees, filtered_step, zero pad
  logic [3:0]   m_axis_tuser;        // motor_out[2:0], calibrating[3]
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  cfg_reg_t     cfg_index = REG_CALIB_LIMIT;
  logic [7:0]   cfg_data = '0;

  motor_encoder_multiturn_tracker dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // Tracker state, one copy per motor slot, plus the shared calibration settings
  logic [5:0] calib_limit_q = 6'd50;
  logic [7:0] calib_mask_q  = 8'h0f;
  logic [5:0] frames_seen [MOTORS] = '{default: '0};
  int         prev_angle  [MOTORS] = '{default: 0};
  int         zero_angle  [MOTORS] = '{default: 0};
  int         turn_total  [MOTORS] = '{default: 0};
  int         step_hist   [MOTORS][WIN_LEN] = '{default: '{default: 0}};
  int         hist_ptr    [MOTORS] = '{default: 0};
  int         hist_sum    [MOTORS] = '{default: 0};

  frame_result_t pending_results[$];
  int            mismatch_count = 0;

  // Stimulus side: rotor position per motor, sender bursts, receiver stalls
  int          rotor_pos [MOTORS] = '{default: 0};
  int unsigned burst_left = 0;
  bit          gaps_on = 1'b1;
  bit          stalls_on = 1'b1;
  int          hold_requests = 0;
  int          holds_served = 0;
  int          hold_left = 0;
  logic [15:0] ready_pattern = 16'hffff;
  logic [3:0]  ready_phase = '0;

  function automatic frame_result_t track_frame(input logic [2:0] m, input logic [12:0] ang,
                                                input logic signed [15:0] spd);
    frame_result_t r;
    logic [5:0]    prior;
    int            delta;
    int            step;
    int            slot;
    longint        total;
    r = '0;
    r.motor = m;
    r.speed = spd;
    prior = frames_seen[m];
    if (prior != 6'd63) frames_seen[m] = prior + 6'd1;
    r.calib = calib_mask_q[m] && (prior <= calib_limit_q);
    if (r.calib) begin
      prev_angle[m] = int'(ang);
      zero_angle[m] = int'(ang);
    end else begin
      delta = int'(ang) - prev_angle[m];
      prev_angle[m] = int'(ang);
      if (delta > HALF_COUNTS) begin
        if (turn_total[m] > TURN_BOTTOM) turn_total[m]--;
        step = delta - TURN_COUNTS;
      end else if (delta < -HALF_COUNTS) begin
        if (turn_total[m] < TURN_TOP) turn_total[m]++;
        step = delta + TURN_COUNTS;
      end else begin
        step = delta;
      end
      total = longint'(turn_total[m]) * TURN_COUNTS + int'(ang) - zero_angle[m];
      r.step = step;
      r.total = total;
      r.degrees = total * 360 / TURN_COUNTS;
      slot = hist_ptr[m];
      hist_sum[m] = hist_sum[m] - step_hist[m][slot] + step;
      step_hist[m][slot] = step;
      hist_ptr[m] = (slot + 1) % WIN_LEN;
      r.filt = hist_sum[m] / WIN_LEN;
    end
    r.turns = turn_total[m];
    return r;
  endfunction

  function automatic logic [12:0] advance_rotor(input int m, input int delta);
    rotor_pos[m] = (rotor_pos[m] + delta) & (TURN_COUNTS - 1);
    return 13'(rotor_pos[m]);
  endfunction

  // Mostly smooth rotation, some moves right at half a turn, some jumps
  function automatic logic [12:0] next_angle(input int m);
    int pick;
    int delta;
    pick = $urandom_range(0, 99);
    if (pick < 70) delta = int'($urandom_range(0, 1200)) - 600;
    else if (pick < 85) delta = ($urandom_range(0, 1) ? 1 : -1) * int'($urandom_range(4094, 4098));
    else delta = $urandom_range(0, TURN_COUNTS - 1);
    return advance_rotor(m, delta);
  endfunction

  function automatic logic signed [15:0] random_speed();
    if ($urandom_range(0, 9) == 0) return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
    return 16'($urandom);
  endfunction

  task automatic idle_for(input int unsigned cycles);
    s_axis_tvalid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic send_frame(input logic [2:0] m, input logic [12:0] ang,
                            input logic signed [15:0] spd);
    int unsigned gap;
    if (gaps_on && burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
      if (gap > 0) idle_for(gap);
    end
    if (burst_left > 0) burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {3'b000, spd, ang};
    s_axis_tuser  <= m;
    do @(posedge clk); while (!s_axis_tready);
    pending_results.push_back(track_frame(m, ang, spd));
  endtask

  // Always advances the clock before checking, so the next drive lands in a new step
  task automatic wait_all_results();
    int guard;
    guard = 0;
    s_axis_tvalid <= 1'b0;
    do begin
      @(posedge clk);
      guard++;
    end while (pending_results.size() != 0 && guard < 50000);
  endtask

  task automatic set_calibration(input logic [5:0] limit, input logic [7:0] mask);
    cfg_valid <= 1'b1;
    cfg_index <= REG_CALIB_LIMIT;
    cfg_data  <= {2'($urandom), limit};   // upper bits are outside the register
    do @(posedge clk); while (!cfg_ready);
    calib_limit_q = limit;
    cfg_index <= REG_CALIB_MASK;
    cfg_data  <= mask;
    do @(posedge clk); while (!cfg_ready);
    calib_mask_q = mask;
    cfg_valid <= 1'b0;
  endtask

  // Receiver: long hold-offs on request, otherwise a rotating ready pattern, or always ready with stalls off
  always @(posedge clk) begin
    if (hold_left > 0) begin
      m_axis_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (holds_served != hold_requests) begin
      holds_served <= holds_served + 1;
      hold_left <= HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else if (!stalls_on) begin
      m_axis_tready <= 1'b1;
    end else begin
      m_axis_tready <= ready_pattern[ready_phase];
      ready_phase <= ready_phase + 4'd1;
      if (ready_phase == 4'hf && $urandom_range(0, 3) == 0)
        ready_pattern <= ($urandom_range(0, 2) == 0) ? 16'hffff : (16'($urandom) | 16'h8421);
    end
  end

  task automatic compare_field(input string field, input longint want, input longint got);
    if (want != got) begin
      mismatch_count++;
      $error("%s: expected %0d, got %0d", field, want, got);
    end
  endtask

  always @(posedge clk) begin
    frame_result_t got;
    frame_result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.motor   = m_axis_tuser[2:0];
      got.calib   = m_axis_tuser[3];
      got.speed   = m_axis_tdata[15:0];
      got.step    = m_axis_tdata[29:16];
      got.turns   = m_axis_tdata[45:30];
      got.total   = m_axis_tdata[75:46];
      got.degrees = m_axis_tdata[100:76];
      got.filt    = m_axis_tdata[114:101];
      if (pending_results.size() == 0) begin
        mismatch_count++;
        $error("result item with no frame pending");
      end else begin
        want = pending_results.pop_front();
        compare_field("motor_out", want.motor, got.motor);
        compare_field("calibrating", want.calib, got.calib);
        compare_field("speed_out", want.speed, got.speed);
        compare_field("angle_step", want.step, got.step);
        compare_field("turns", want.turns, got.turns);
        compare_field("total_counts", want.total, got.total);
        compare_field("total_degrees", want.degrees, got.degrees);
        compare_field("filtered_step", want.filt, got.filt);
      end
    end
  end

  // Reset settings: motors 0..3 calibrate, 4..7 track from the first frame
  task automatic test_unwrap_edges();
    send_frame(3'd0, 13'd100, 16'sh8000);
    send_frame(3'd5, 13'd8191, 16'sh7fff);   // backward wrap
    send_frame(3'd5, 13'd0, 16'sh0000);      // forward wrap
    send_frame(3'd5, 13'd4096, 16'sh0001);   // exactly half a turn forward
    send_frame(3'd5, 13'd0, -16'sd1);        // exactly half a turn back
    send_frame(3'd5, 13'd4097, 16'sh1234);   // just past half a turn
    send_frame(3'd5, 13'd4097, 16'sh4321);
    send_frame(3'd5, 13'd8191, 16'sh5555);
    send_frame(3'd3, 13'd0, 16'shaaaa);
    wait_all_results();
  endtask

  task automatic test_offset_capture();
    set_calibration(6'd0, 8'hff);
    send_frame(3'd1, 13'd5000, 16'sh0100);   // first frame only sets the offset
    send_frame(3'd1, 13'd5000, 16'sh0200);
    send_frame(3'd1, 13'd100, 16'sh0300);
    send_frame(3'd1, 13'd4999, 16'sh0400);
    send_frame(3'd0, 13'd8000, 16'sh0500);   // negative total
    send_frame(3'd2, 13'd1234, 16'sh0600);
    send_frame(3'd2, 13'd1233, 16'sh0700);
    wait_all_results();
    // limit of 63 keeps a masked motor calibrating for good
    set_calibration(6'd63, 8'h80);
    send_frame(3'd7, 13'd3, 16'sh7fff);
    send_frame(3'd7, 13'd7000, 16'sh8000);
    send_frame(3'd7, 13'd12, 16'sh0000);
    send_frame(3'd6, 13'd4095, 16'sh0001);
    wait_all_results();
  endtask

  task automatic test_random_stream(input int items);
    logic [2:0] m;
    for (int i = 0; i < items; i++) begin
      m = 3'($urandom_range(0, MOTORS - 1));
      send_frame(m, next_angle(m), random_speed());
    end
  endtask

  task automatic test_config_sweep();
    logic [5:0] limits [6];
    logic [7:0] masks [6];
    limits = '{6'd0, 6'd63, 6'($urandom_range(0, 62)), 6'd62, 6'($urandom_range(0, 62)), 6'd30};
    masks  = '{8'hff, 8'h5a, 8'($urandom), 8'h00, 8'($urandom), 8'hff};
    for (int p = 0; p < 6; p++) begin
      wait_all_results();
      set_calibration(limits[p], masks[p]);
      test_random_stream(PHASE_ITEMS);
    end
    wait_all_results();
  endtask

  // Hold the output off long enough that the block fills and stalls its input
  task automatic test_output_backpressure();
    hold_requests++;
    test_random_stream(60);
    wait_all_results();
  endtask

  // Spin one motor fast forward, then fast backward, back to back
  task automatic test_fast_spin();
    gaps_on = 1'b0;
    stalls_on = 1'b0;
    set_calibration(6'd0, 8'h00);
    repeat (SPIN_ITEMS) send_frame(3'd6, advance_rotor(6, 4095), random_speed());
    repeat (SPIN_ITEMS) send_frame(3'd6, advance_rotor(6, -4095), random_speed());
    wait_all_results();
    gaps_on = 1'b1;
    stalls_on = 1'b1;
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_unwrap_edges();
    test_offset_capture();
    test_config_sweep();
    test_output_backpressure();
    test_fast_spin();
    set_calibration(6'd20, 8'hc3);
    test_random_stream(100);
    wait_all_results();
    repeat (20) @(posedge clk);
    if (pending_results.size() != 0) begin
      mismatch_count++;
      $error("%0d result items never arrived", pending_results.size());
    end
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
